// File: sv/bqld_pkg.sv
package bqld_pkg;

    localparam int NUM_CORES  = 4;
    localparam int NUM_BANDS  = 3;
    localparam int BAND_DEPTH = 8;
    localparam int RUNQ_DEPTH = 16;

    localparam int CORE_W  = 2;
    localparam int BAND_W  = 2;
    localparam int BPTR_W  = $clog2(BAND_DEPTH);
    localparam int BCNT_W  = $clog2(BAND_DEPTH + 1);
    localparam int RPTR_W  = $clog2(RUNQ_DEPTH);
    localparam int RCNT_W  = $clog2(RUNQ_DEPTH + 1);
    localparam int CIDX_W  = $clog2(NUM_CORES);
    localparam int CSCAN_W = $clog2(NUM_CORES + 1);
    localparam int BADDR_W = $clog2(NUM_BANDS * BAND_DEPTH);
    localparam int RADDR_W = $clog2(NUM_CORES * RUNQ_DEPTH);
    localparam int MAP_W   = 4;

    typedef enum logic [1:0] {
        MODE_SUBMIT = 2'd0,
        MODE_DRAIN  = 2'd1,
        MODE_PULL   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_ACCEPTED   = 3'd0,
        KIND_BAD_PRIO   = 3'd1,
        KIND_BAND_FULL  = 3'd2,
        KIND_DISPATCHED = 3'd3,
        KIND_RUNQ_FULL  = 3'd4,
        KIND_PULLED     = 3'd5,
        KIND_EMPTY      = 3'd6,
        KIND_UNUSED     = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        CFG_HIGH_TOP = 3'd0,
        CFG_MED_TOP  = 3'd1,
        CFG_LOW_TOP  = 3'd2,
        CFG_HIGH_DIV = 3'd3,
        CFG_MED_DIV  = 3'd4,
        CFG_LOW_DIV  = 3'd5,
        CFG_GROUP    = 3'd6,
        CFG_SPARE    = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BAND,
        ST_CHUNK,
        ST_READ,
        ST_SCAN,
        ST_PLACE,
        ST_EMIT,
        ST_PULL,
        ST_SUBMIT_OUT,
        ST_WAIT_OUT
    } state_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] process_id;
        logic [4:0] priority_req;
        logic       has_home;
        logic [1:0] home_core;
        logic [1:0] pull_core;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] result_id;
        logic [1:0] result_core;
        logic       last;
    } out_item_t;

    // Request to the shared scan unit and its answer.
    typedef struct packed {
        logic                start;
        logic                restrict_grp;
        logic                group;
        logic [MAP_W-1:0]    group_map;
    } scan_req_t;

    typedef struct packed {
        logic              done;
        logic [CIDX_W-1:0] core;
    } scan_rsp_t;

    function automatic logic group_of(input logic [MAP_W-1:0] map, input int unsigned core);
        logic g;
        g = 1'b0;
        if (core < MAP_W)
        begin
            g = map[core];
        end
        return g;
    endfunction

endpackage

// File: sv/bqld_scan.sv
// Walks the cores one per cycle and keeps the shortest run queue seen among the eligible cores.
module bqld_scan (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bqld_pkg::scan_req_t                  req,
    input  logic [bqld_pkg::NUM_CORES-1:0][bqld_pkg::RCNT_W-1:0] counts,
    output bqld_pkg::scan_rsp_t                  rsp
);
    logic                            busy_reg, busy_next;
    logic [bqld_pkg::CSCAN_W-1:0]    idx_reg, idx_next;
    logic [bqld_pkg::CIDX_W-1:0]     best_reg, best_next;
    logic [bqld_pkg::RCNT_W:0]       best_len_reg, best_len_next;
    logic                            done_reg, done_next;
    logic [bqld_pkg::CIDX_W-1:0]     cur;
    logic                            eligible;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        best_reg     <= best_next;
        best_len_reg <= best_len_next;
    end

    always_comb
    begin
        cur           = idx_reg[bqld_pkg::CIDX_W-1:0];
        eligible      = !req.restrict_grp
                        || (bqld_pkg::group_of(req.group_map, 32'(cur)) == req.group);
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        best_next     = best_reg;
        best_len_next = best_len_reg;
        done_next     = 1'b0;
        if (req.start)
        begin
            busy_next     = 1'b1;
            idx_next      = '0;
            best_next     = '0;
            best_len_next = '1;
        end
        else if (busy_reg)
        begin
            if (eligible && ({1'b0, counts[cur]} < best_len_reg))
            begin
                best_next     = cur;
                best_len_next = {1'b0, counts[cur]};
            end
            idx_next = idx_reg + 1'b1;
            if (idx_reg == bqld_pkg::CSCAN_W'(bqld_pkg::NUM_CORES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        rsp.done = done_reg;
        rsp.core = best_reg;
    end

endmodule

// File: sv/bqld_ctrl.sv
module bqld_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bqld_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bqld_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [4:0]           cfg_data
);
    localparam int NB = bqld_pkg::NUM_BANDS;
    localparam int NC = bqld_pkg::NUM_CORES;

    bqld_pkg::state_t state_reg, state_next;

    logic [4:0] top_reg [3];
    logic [3:0] div_reg [3];
    logic [bqld_pkg::MAP_W-1:0] map_reg;

    logic [NB-1:0][bqld_pkg::BPTR_W-1:0] bhead_reg, bhead_next;
    logic [NB-1:0][bqld_pkg::BCNT_W-1:0] bcnt_reg, bcnt_next;
    logic [NC-1:0][bqld_pkg::RPTR_W-1:0] rhead_reg, rhead_next;
    logic [NC-1:0][bqld_pkg::RCNT_W-1:0] rcnt_reg, rcnt_next;

    logic [10:0] band_mem [NB * bqld_pkg::BAND_DEPTH];
    logic [7:0]  runq_mem [NC * bqld_pkg::RUNQ_DEPTH];

    bqld_pkg::in_item_t  item_reg, item_next;
    bqld_pkg::out_item_t obuf_reg, obuf_next;
    logic                ovalid_reg, ovalid_next;
    logic [bqld_pkg::BAND_W-1:0]  band_reg, band_next;
    logic [bqld_pkg::BCNT_W-1:0]  chunk_reg, chunk_next;
    logic [bqld_pkg::BCNT_W-1:0]  rem_reg, rem_next;
    logic                         any_reg, any_next;
    logic [10:0]                  entry_reg;
    logic [7:0]                   rq_rd_reg;
    logic [bqld_pkg::CIDX_W-1:0]  core_reg, core_next;

    logic                         bwe, rwe, bre, rre;
    logic [bqld_pkg::BADDR_W-1:0] baddr;
    logic [bqld_pkg::RADDR_W-1:0] raddr;
    logic [10:0]                  bwdata;
    logic [bqld_pkg::BCNT_W-1:0]  len, q;
    logic [bqld_pkg::BCNT_W+3:0]  prod;
    logic [3:0]                   dv;
    logic [bqld_pkg::BAND_W-1:0]  sb;
    logic                         sb_ok;
    logic                         in_acc, out_acc, last_band;
    logic [bqld_pkg::CIDX_W-1:0]  pc;

    bqld_pkg::scan_req_t sreq;
    bqld_pkg::scan_rsp_t srsp;

    bqld_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (sreq),
        .counts (rcnt_reg),
        .rsp    (srsp)
    );

    assign cfg_ready = (state_reg == bqld_pkg::ST_IDLE) && !ovalid_reg;
    assign in_stall  = !((state_reg == bqld_pkg::ST_IDLE) && !ovalid_reg);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = ovalid_reg;
    assign out_data  = obuf_reg;
    assign out_acc   = ovalid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bqld_pkg::ST_IDLE;
            top_reg[0] <= 5'd5;
            top_reg[1] <= 5'd14;
            top_reg[2] <= 5'd19;
            div_reg[0] <= 4'd2;
            div_reg[1] <= 4'd3;
            div_reg[2] <= 4'd6;
            map_reg    <= 4'd10;
            bhead_reg  <= '0;
            bcnt_reg   <= '0;
            rhead_reg  <= '0;
            rcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bhead_reg  <= bhead_next;
            bcnt_reg   <= bcnt_next;
            rhead_reg  <= rhead_next;
            rcnt_reg   <= rcnt_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (bqld_pkg::cfg_index_t'(cfg_index))
                    bqld_pkg::CFG_HIGH_TOP: top_reg[0] <= cfg_data;
                    bqld_pkg::CFG_MED_TOP:  top_reg[1] <= cfg_data;
                    bqld_pkg::CFG_LOW_TOP:  top_reg[2] <= cfg_data;
                    bqld_pkg::CFG_HIGH_DIV: div_reg[0] <= cfg_data[3:0];
                    bqld_pkg::CFG_MED_DIV:  div_reg[1] <= cfg_data[3:0];
                    bqld_pkg::CFG_LOW_DIV:  div_reg[2] <= cfg_data[3:0];
                    bqld_pkg::CFG_GROUP:    map_reg    <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        obuf_reg  <= obuf_next;
        band_reg  <= band_next;
        chunk_reg <= chunk_next;
        rem_reg   <= rem_next;
        any_reg   <= any_next;
        core_reg  <= core_next;
        if (bwe)
        begin
            band_mem[baddr] <= bwdata;
        end
        if (bre)
        begin
            entry_reg <= band_mem[baddr];
        end
        if (rwe)
        begin
            runq_mem[raddr] <= entry_reg[7:0];
        end
        if (rre)
        begin
            rq_rd_reg <= runq_mem[raddr];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        bhead_next  = bhead_reg;
        bcnt_next   = bcnt_reg;
        rhead_next  = rhead_reg;
        rcnt_next   = rcnt_reg;
        ovalid_next = ovalid_reg;
        item_next   = item_reg;
        obuf_next   = obuf_reg;
        band_next   = band_reg;
        chunk_next  = chunk_reg;
        rem_next    = rem_reg;
        any_next    = any_reg;
        core_next   = core_reg;
        bwe = 1'b0;
        bre = 1'b0;
        rwe = 1'b0;
        rre = 1'b0;
        baddr  = '0;
        raddr  = '0;
        bwdata = {item_reg.home_core, item_reg.has_home, item_reg.process_id};
        sreq.start        = 1'b0;
        sreq.restrict_grp = entry_reg[8];
        sreq.group        = bqld_pkg::group_of(map_reg, 32'(entry_reg[10:9]));
        sreq.group_map    = map_reg;
        last_band = (band_reg == bqld_pkg::BAND_W'(NB - 1));
        pc   = item_reg.pull_core[bqld_pkg::CIDX_W-1:0];

        // Band choice for a submit.
        sb_ok = 1'b1;
        if (item_reg.priority_req <= top_reg[0])
        begin
            sb = 2'd0;
        end
        else if (item_reg.priority_req <= top_reg[1])
        begin
            sb = 2'd1;
        end
        else
        begin
            sb    = 2'd2;
            sb_ok = (item_reg.priority_req <= top_reg[2]);
        end

        // Chunk size by a small quotient search: length is at most the band depth.
        len = bcnt_reg[band_reg];
        dv  = (div_reg[band_reg] == 4'd0) ? 4'd1 : div_reg[band_reg];
        q    = chunk_reg;
        prod = (bqld_pkg::BCNT_W + 4)'(chunk_reg + 1'b1) * (bqld_pkg::BCNT_W + 4)'(dv);

        if (out_acc)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            bqld_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    item_next = in_data;
                    unique case (bqld_pkg::mode_t'(in_data.mode))
                        bqld_pkg::MODE_SUBMIT: state_next = bqld_pkg::ST_SUBMIT_OUT;
                        bqld_pkg::MODE_DRAIN:
                        begin
                            band_next  = '0;
                            chunk_next = '0;
                            any_next   = 1'b0;
                            state_next = bqld_pkg::ST_CHUNK;
                        end
                        bqld_pkg::MODE_PULL:   state_next = bqld_pkg::ST_PULL;
                        default: ;
                    endcase
                end
            end
            bqld_pkg::ST_SUBMIT_OUT:
            begin
                obuf_next.result_id   = item_reg.process_id;
                obuf_next.result_core = '0;
                obuf_next.last        = 1'b1;
                if (!sb_ok)
                begin
                    obuf_next.kind = bqld_pkg::KIND_BAD_PRIO;
                end
                else if (bcnt_reg[sb] >= bqld_pkg::BCNT_W'(bqld_pkg::BAND_DEPTH))
                begin
                    obuf_next.kind = bqld_pkg::KIND_BAND_FULL;
                end
                else
                begin
                    obuf_next.kind = bqld_pkg::KIND_ACCEPTED;
                    bwe   = 1'b1;
                    baddr = bqld_pkg::BADDR_W'(32'(sb) * bqld_pkg::BAND_DEPTH
                            + 32'(bqld_pkg::BPTR_W'(bhead_reg[sb]
                            + bcnt_reg[sb][bqld_pkg::BPTR_W-1:0])));
                    bcnt_next[sb] = bcnt_reg[sb] + 1'b1;
                end
                ovalid_next = 1'b1;
                state_next  = bqld_pkg::ST_IDLE;
            end
            bqld_pkg::ST_PULL:
            begin
                obuf_next.result_core = item_reg.pull_core;
                obuf_next.last        = 1'b1;
                if (32'(item_reg.pull_core) >= NC || rcnt_reg[pc] == '0)
                begin
                    obuf_next.kind      = bqld_pkg::KIND_EMPTY;
                    obuf_next.result_id = '0;
                    ovalid_next = 1'b1;
                    state_next  = bqld_pkg::ST_IDLE;
                end
                else
                begin
                    rre   = 1'b1;
                    raddr = bqld_pkg::RADDR_W'(32'(pc) * bqld_pkg::RUNQ_DEPTH
                            + 32'(rhead_reg[pc]));
                    rhead_next[pc] = rhead_reg[pc] + 1'b1;
                    rcnt_next[pc]  = rcnt_reg[pc] - 1'b1;
                    obuf_next.kind = bqld_pkg::KIND_PULLED;
                    state_next     = bqld_pkg::ST_WAIT_OUT;
                end
            end
            bqld_pkg::ST_WAIT_OUT:
            begin
                obuf_next.result_id = rq_rd_reg;
                ovalid_next = 1'b1;
                state_next  = bqld_pkg::ST_IDLE;
            end
            bqld_pkg::ST_CHUNK:
            begin
                // Count up while (q+1)*d <= len, one step a cycle.
                if (prod <= (bqld_pkg::BCNT_W + 4)'(len))
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
                else
                begin
                    rem_next   = (q == '0) ? len : q;
                    if (q == '0 && len != '0)
                    begin
                        rem_next = bqld_pkg::BCNT_W'(1);
                    end
                    state_next = bqld_pkg::ST_BAND;
                end
            end
            bqld_pkg::ST_BAND:
            begin
                if (rem_reg == '0)
                begin
                    if (last_band)
                    begin
                        if (!any_reg)
                        begin
                            obuf_next.kind        = bqld_pkg::KIND_EMPTY;
                            obuf_next.result_id   = '0;
                            obuf_next.result_core = '0;
                            obuf_next.last        = 1'b1;
                            ovalid_next = 1'b1;
                        end
                        state_next = bqld_pkg::ST_IDLE;
                    end
                    else
                    begin
                        band_next  = band_reg + 1'b1;
                        chunk_next = '0;
                        state_next = bqld_pkg::ST_CHUNK;
                    end
                end
                else if (!ovalid_reg || out_acc)
                begin
                    bre   = 1'b1;
                    baddr = bqld_pkg::BADDR_W'(32'(band_reg) * bqld_pkg::BAND_DEPTH
                            + 32'(bhead_reg[band_reg]));
                    bhead_next[band_reg] = bhead_reg[band_reg] + 1'b1;
                    bcnt_next[band_reg]  = bcnt_reg[band_reg] - 1'b1;
                    rem_next   = rem_reg - 1'b1;
                    state_next = bqld_pkg::ST_READ;
                end
            end
            bqld_pkg::ST_READ:
            begin
                sreq.start = 1'b1;
                state_next = bqld_pkg::ST_SCAN;
            end
            bqld_pkg::ST_SCAN:
            begin
                if (srsp.done)
                begin
                    core_next  = srsp.core;
                    state_next = bqld_pkg::ST_PLACE;
                end
            end
            bqld_pkg::ST_PLACE:
            begin
                obuf_next.result_id   = entry_reg[7:0];
                obuf_next.result_core = bqld_pkg::CORE_W'(core_reg);
                if (rcnt_reg[core_reg] >= bqld_pkg::RCNT_W'(bqld_pkg::RUNQ_DEPTH))
                begin
                    obuf_next.kind = bqld_pkg::KIND_RUNQ_FULL;
                end
                else
                begin
                    obuf_next.kind = bqld_pkg::KIND_DISPATCHED;
                    rwe   = 1'b1;
                    raddr = bqld_pkg::RADDR_W'(32'(core_reg) * bqld_pkg::RUNQ_DEPTH
                            + 32'(bqld_pkg::RPTR_W'(rhead_reg[core_reg]
                            + rcnt_reg[core_reg][bqld_pkg::RPTR_W-1:0])));
                    rcnt_next[core_reg] = rcnt_reg[core_reg] + 1'b1;
                end
                any_next   = 1'b1;
                state_next = bqld_pkg::ST_EMIT;
            end
            bqld_pkg::ST_EMIT:
            begin
                // Last result when this band's chunk is done and no later band has anything to give.
                obuf_next.last = (rem_reg == '0)
                    && ((band_reg == 2'd2)
                    || (band_reg == 2'd1 && bcnt_reg[2] == '0)
                    || (band_reg == 2'd0 && bcnt_reg[1] == '0 && bcnt_reg[2] == '0));
                ovalid_next = 1'b1;
                state_next  = bqld_pkg::ST_BAND;
            end
            default: state_next = bqld_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: sv/band_queue_least_loaded_dispatcher.sv
// Band-queue dispatcher. One item is taken at a time, and the input stalls until
// its last result has been transferred. A submit registers its result in
// ST_SUBMIT_OUT; a pull that finds an entry goes through ST_PULL and then
// ST_WAIT_OUT, as the run-queue read is registered. A drain runs, per band, the
// chunk search one quotient step at a time, and then for each dispatched
// process: the band read, the scan start, a walk over the cores through the
// shared compare unit and its return, placement and the result. A stalled
// result holds back the next band read. in_data carries the process payload,
// out_data the results.
module band_queue_least_loaded_dispatcher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bqld_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bqld_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [4:0]          cfg_data
);
    bqld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );
endmodule

// File: sv/bqld_checker.sv
module bqld_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input bqld_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input bqld_pkg::out_item_t out_data,
    input logic                cfg_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.kind != bqld_pkg::KIND_UNUSED)
        else $error("bad result kind");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> cfg_ready && !out_valid)
        else $error("input taken while busy");
    // An item of the unused mode gives no result, so the input stays open.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.mode != bqld_pkg::MODE_NONE) |=> in_stall)
        else $error("second item taken at once");
endmodule

bind band_queue_least_loaded_dispatcher bqld_checker u_bqld_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_ready (cfg_ready)
);
